// ===== rtl/core/test_signal_generator_macros.svh =====
// Assertion macros for the test signal generator checker.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef TEST_SIGNAL_GENERATOR_MACROS_SVH
`define TEST_SIGNAL_GENERATOR_MACROS_SVH

// Clocked property, muted while reset is high.
`define TSG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define TSG_ASSERT_NORST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/tsg_pkg.sv =====
// Shared widths, codes and the wavelet table for the test signal generator.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package tsg_pkg;

   // position fraction bits of the wavelet table lookup (4..16)
   localparam int POS_FRAC_BITS = 8;

   // field widths
   localparam int AMP_W      = 9;
   localparam int TC_W       = 16;
   localparam int WAVE_W     = 2;
   localparam int TIME_W     = 32;
   localparam int SIG_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SIG_LIMIT  = 600;

   // wavelet table: Q2.14 entries, 61 of them
   localparam int TAB_W     = 16;
   localparam int TAB_IDX_W = 6;
   localparam int TAB_LAST  = 60;
   localparam int Q_FRAC    = 14;

   // wavelet position: 7 integer bits (below 120) plus the fraction
   localparam int WAV_IDX_W = 7;
   localparam int WAV_SHIFT = 3 + POS_FRAC_BITS;

   // serial divider: quotient holds a position; remainder is as wide as tc
   localparam int DIV_Q_W   = WAV_IDX_W + POS_FRAC_BITS;
   localparam int DIV_N_W   = DIV_Q_W + TC_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);
   localparam int WAV_DT_W  = DIV_N_W - WAV_SHIFT;

   // serial multiplier: magnitude of an interpolated value times amplitude
   localparam int MUL_M_W    = TAB_W - 1 + POS_FRAC_BITS;
   localparam int MUL_P_W    = MUL_M_W + AMP_W;
   localparam int MUL_CNT_W  = $clog2(AMP_W + 1);
   localparam int TRI_PROD_W = AMP_W + TC_W;

   // interpolated value, signed, Q(14+F)
   localparam int V_W         = TAB_W + 2 + POS_FRAC_BITS;
   localparam int SCALE_SHIFT = Q_FRAC + POS_FRAC_BITS;
   localparam int MAG_W       = MUL_P_W - SCALE_SHIFT;

   // codes
   localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [WAVE_W-1:0] WAVE_WAVELET  = 2'd2;
   localparam logic              OP_START      = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMPLITUDE    = 2'd0,
      CSR_TIME_CONST   = 2'd1,
      CSR_WAVE_TYPE    = 2'd2,
      CSR_DIRECTION_UP = 2'd3
   } csr_index_type;

   function automatic logic signed [TAB_W-1:0] wave_q14(input logic [TAB_IDX_W-1:0] i);
      logic signed [TAB_W-1:0] t;
      case (i)
         6'd0:  t = 16'sd10;     6'd1:  t = -16'sd8;     6'd2:  t = -16'sd28;
         6'd3:  t = -16'sd48;    6'd4:  t = -16'sd64;    6'd5:  t = -16'sd75;
         6'd6:  t = -16'sd79;    6'd7:  t = -16'sd72;    6'd8:  t = -16'sd51;
         6'd9:  t = -16'sd13;    6'd10: t = 16'sd38;     6'd11: t = 16'sd92;
         6'd12: t = 16'sd141;    6'd13: t = 16'sd175;    6'd14: t = 16'sd190;
         6'd15: t = 16'sd182;    6'd16: t = 16'sd146;    6'd17: t = 16'sd77;
         6'd18: t = -16'sd21;    6'd19: t = -16'sd139;   6'd20: t = -16'sd259;
         6'd21: t = -16'sd357;   6'd22: t = -16'sd413;   6'd23: t = -16'sd416;
         6'd24: t = -16'sd356;   6'd25: t = -16'sd228;   6'd26: t = -16'sd38;
         6'd27: t = 16'sd202;    6'd28: t = 16'sd444;    6'd29: t = 16'sd636;
         6'd30: t = 16'sd727;    6'd31: t = 16'sd709;    6'd32: t = 16'sd618;
         6'd33: t = 16'sd498;    6'd34: t = 16'sd356;    6'd35: t = 16'sd128;
         6'd36: t = -16'sd285;   6'd37: t = -16'sd908;   6'd38: t = -16'sd1602;
         6'd39: t = -16'sd2071;  6'd40: t = -16'sd1987;  6'd41: t = -16'sd1235;
         6'd42: t = -16'sd54;    6'd43: t = 16'sd1031;   6'd44: t = 16'sd1517;
         6'd45: t = 16'sd1294;   6'd46: t = 16'sd819;    6'd47: t = 16'sd863;
         6'd48: t = 16'sd1948;   6'd49: t = 16'sd3770;   6'd50: t = 16'sd5100;
         6'd51: t = 16'sd4350;   6'd52: t = 16'sd608;    6'd53: t = -16'sd5462;
         6'd54: t = -16'sd11503; 6'd55: t = -16'sd14405; 6'd56: t = -16'sd11914;
         6'd57: t = -16'sd4062;  6'd58: t = 16'sd6477;   6'd59: t = 16'sd15430;
         6'd60: t = 16'sd18930;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/core/tsg_req_if.sv =====
// Request channel of the test signal generator: valid/ready plus op and time.
// Depends on tsg_pkg.
`timescale 1ns / 1ps

interface tsg_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [tsg_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output op, output now_ms, input ready);
   modport sink   (input valid, input op, input now_ms, output ready);
endinterface

// ===== rtl/core/tsg_rsp_if.sv =====
// Response channel of the test signal generator: valid/ready plus the sample.
// Depends on tsg_pkg.
`timescale 1ns / 1ps

interface tsg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tsg_pkg::SIG_W-1:0]   signal;
   logic                               active;

   modport source (output valid, output signal, output active, input ready);
   modport sink   (input valid, input signal, input active, output ready);
endinterface

// ===== rtl/core/tsg_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on tsg_pkg.
`timescale 1ns / 1ps

module tsg_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsg_pkg::MUL_M_W-1:0]   mcand,
   input  logic [tsg_pkg::AMP_W-1:0]     mplier,
   output logic [tsg_pkg::MUL_P_W-1:0]   product,
   output logic                          done
);

   logic [tsg_pkg::MUL_P_W-1:0]   prod_ff, prod_in;
   logic [tsg_pkg::MUL_M_W-1:0]   mcand_ff, mcand_in;
   logic [tsg_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tsg_pkg::MUL_M_W:0]     sum;

   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      // add into the upper half, then shift the whole word right
      sum = {1'b0, prod_ff[tsg_pkg::MUL_P_W-1:tsg_pkg::AMP_W]}
          + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         prod_in  = {{tsg_pkg::MUL_M_W{1'b0}}, mplier};
         mcand_in = mcand;
         cnt_in   = tsg_pkg::MUL_CNT_W'(tsg_pkg::AMP_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[tsg_pkg::AMP_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == tsg_pkg::MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign product = prod_ff;
   assign done    = done_ff;

endmodule

// ===== rtl/core/tsg_div.sv =====
// Restoring divider, one quotient bit per cycle, MSB first.
// Needs dividend < divisor * 2^DIV_Q_W. Depends on tsg_pkg.
`timescale 1ns / 1ps

module tsg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsg_pkg::DIV_N_W-1:0]   dividend,
   input  logic [tsg_pkg::TC_W-1:0]      divisor,
   output logic [tsg_pkg::DIV_Q_W-1:0]   quotient,
   output logic                          done
);

   logic [tsg_pkg::TC_W-1:0]      rem_ff, rem_in;
   logic [tsg_pkg::DIV_Q_W-1:0]   quo_ff, quo_in;
   logic [tsg_pkg::TC_W-1:0]      dvs_ff, dvs_in;
   logic [tsg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tsg_pkg::TC_W:0]        trial;
   logic [tsg_pkg::TC_W:0]        diff;
   logic                          fits;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // quo_ff shifts dividend bits out at the top and quotient bits in at the bottom
      trial = {rem_ff, quo_ff[tsg_pkg::DIV_Q_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
      if (start) begin
         rem_in  = dividend[tsg_pkg::DIV_N_W-1:tsg_pkg::DIV_Q_W];
         quo_in  = dividend[tsg_pkg::DIV_Q_W-1:0];
         dvs_in  = divisor;
         cnt_in  = tsg_pkg::DIV_CNT_W'(tsg_pkg::DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tsg_pkg::TC_W-1:0] : trial[tsg_pkg::TC_W-1:0];
         quo_in = {quo_ff[tsg_pkg::DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tsg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/core/test_signal_generator.sv =====
// Test signal generator: one-shot doublet, triangle or wavelet excitation.
// Start and arm requests go from decode straight to output, out-of-range ticks via eval;
//   a triangle tick multiplies, then divides; a wavelet tick divides, then multiplies.
// Throughput: one transaction at a time; the next request is taken once the result sits in
//   the response register, so a stalled consumer holds back only the one after that.
// Reset (synchronous, active high): idle phase, start time 0, registers at their defaults.
`timescale 1ns / 1ps

module test_signal_generator (
   input  logic                              clock,
   input  logic                              reset,
   tsg_req_if.sink                           req_chan,
   tsg_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [tsg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int F = tsg_pkg::POS_FRAC_BITS;
   localparam int TRI_WAIT_MS = 1000;   // triangle lead-in before the ramp
   localparam logic [tsg_pkg::DIV_Q_W-1:0] WAV_MIRROR_POS =
      tsg_pkg::DIV_Q_W'((2 * tsg_pkg::TAB_LAST) << F);

   // Sequencer: one-hot
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,  // waiting for a request
      S_DECODE = 9'b000000010,  // phase bookkeeping, elapsed time
      S_EVAL   = 9'b000000100,  // range compares, kick off multiply or divide
      S_MUL    = 9'b000001000,  // serial multiply running
      S_DIV    = 9'b000010000,  // serial divide running
      S_MIRROR = 9'b000100000,  // wavelet: fold second half, split index/fraction
      S_INTERP = 9'b001000000,  // wavelet: table lookup and interpolation
      S_WSTART = 9'b010000000,  // wavelet: magnitude into the multiplier
      S_OUT    = 9'b100000000   // hand result to the response register
   } state_type;

   // Waveform phase, one-hot
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ARMED = 3'b010,
      PH_RUN   = 3'b100
   } phase_type;

   function automatic logic signed [tsg_pkg::SIG_W-1:0] apply_sign(
      input logic [tsg_pkg::MAG_W-1:0] m,
      input logic                      neg
   );
      logic signed [tsg_pkg::SIG_W-1:0] s;
      s = $signed(tsg_pkg::SIG_W'(m));
      return neg ? -s : s;
   endfunction

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type                            state_ff, state_in;
   phase_type                            phase_ff, phase_in;
   logic [tsg_pkg::TIME_W-1:0]           start_ff, start_in;

   // configuration
   logic [tsg_pkg::AMP_W-1:0]            amp_ff, amp_in;
   logic [tsg_pkg::TC_W-1:0]             tc_ff, tc_in;
   logic [tsg_pkg::WAVE_W-1:0]           wave_ff, wave_in;
   logic                                 dir_ff, dir_in;

   // working registers for the transaction in flight
   logic                                 op_ff, op_in;
   logic [tsg_pkg::TIME_W-1:0]           now_ff, now_in;
   logic [tsg_pkg::TIME_W-1:0]           dt_ff, dt_in;
   logic signed [tsg_pkg::SIG_W-1:0]     sig_ff, sig_in;
   logic                                 neg_ff, neg_in;
   logic [tsg_pkg::TAB_IDX_W-1:0]        idx_ff, idx_in;
   logic [F-1:0]                         frac_ff, frac_in;
   logic signed [tsg_pkg::V_W-1:0]       v_ff, v_in;

   // response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [tsg_pkg::SIG_W-1:0]     rsp_signal_ff, rsp_signal_in;
   logic                                 rsp_active_ff, rsp_active_in;

   // ---------------------------------------------------------------------------
   // Serial arithmetic units
   // ---------------------------------------------------------------------------
   logic                                 mul_start;
   logic [tsg_pkg::MUL_M_W-1:0]          mul_mcand;
   logic [tsg_pkg::MUL_P_W-1:0]          mul_product;
   logic                                 mul_done;
   logic                                 div_start;
   logic [tsg_pkg::DIV_N_W-1:0]          div_dividend;
   logic [tsg_pkg::DIV_Q_W-1:0]          div_quotient;
   logic                                 div_done;

   // ---------------------------------------------------------------------------
   // Derived time-constant thresholds (a zero tc counts as 1 ms)
   // ---------------------------------------------------------------------------
   logic [tsg_pkg::TC_W-1:0]             tc_eff;
   logic [tsg_pkg::TC_W:0]               tc2;
   logic [tsg_pkg::TC_W+1:0]             tc3;
   logic [tsg_pkg::TC_W+3:0]             tc13;
   logic [tsg_pkg::TC_W+3:0]             tc15;
   logic [tsg_pkg::TC_W:0]               tri_rise_end;
   logic [tsg_pkg::TC_W+1:0]             tri_fall_end;
   logic [tsg_pkg::TC_W:0]               tri_d;
   logic [tsg_pkg::TC_W:0]               tri_fall;

   // wavelet fold
   logic [tsg_pkg::DIV_Q_W-1:0]          pos_m;
   logic [tsg_pkg::WAV_IDX_W-1:0]        idx_raw;
   logic [tsg_pkg::WAV_IDX_W-1:0]        idx_fold;

   // interpolation
   logic signed [tsg_pkg::TAB_W-1:0]     t0, t1;
   logic signed [tsg_pkg::TAB_W:0]       t_diff;
   logic signed [tsg_pkg::V_W-1:0]       base_v, step_v;
   logic signed [tsg_pkg::V_W-1:0]       abs_v;

   tsg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (amp_ff),
      .product (mul_product),
      .done    (mul_done)
   );

   tsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (tc_eff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      tc_eff       = (tc_ff == '0) ? tsg_pkg::TC_W'(1) : tc_ff;
      tc2          = {tc_eff, 1'b0};
      tc3          = (tsg_pkg::TC_W+2)'(tc2) + (tsg_pkg::TC_W+2)'(tc_eff);
      tc13         = ((tsg_pkg::TC_W+4)'(tc_eff) << 3) + ((tsg_pkg::TC_W+4)'(tc_eff) << 2)
                   + (tsg_pkg::TC_W+4)'(tc_eff);
      tc15         = ((tsg_pkg::TC_W+4)'(tc_eff) << 4) - (tsg_pkg::TC_W+4)'(tc_eff);
      tri_rise_end = (tsg_pkg::TC_W+1)'(tc_eff) + (tsg_pkg::TC_W+1)'(TRI_WAIT_MS);
      tri_fall_end = (tsg_pkg::TC_W+2)'(tc2) + (tsg_pkg::TC_W+2)'(TRI_WAIT_MS);
      // only the low bits of dt - 1000 matter once dt is inside the ramp window
      tri_d        = dt_ff[tsg_pkg::TC_W:0] - (tsg_pkg::TC_W+1)'(TRI_WAIT_MS);
      tri_fall     = tc2 - tri_d;
   end

   // Wavelet: position at or past 60 folds back; an exact 60 clamps to the last entry
   always_comb begin
      idx_raw  = div_quotient[tsg_pkg::DIV_Q_W-1:F];
      pos_m    = (idx_raw >= tsg_pkg::WAV_IDX_W'(tsg_pkg::TAB_LAST))
               ? WAV_MIRROR_POS - div_quotient : div_quotient;
      idx_fold = pos_m[tsg_pkg::DIV_Q_W-1:F];
   end

   // Linear interpolation in Q(14+F); the entry past the end is only read with zero fraction
   always_comb begin
      t0     = tsg_pkg::wave_q14(idx_ff);
      t1     = tsg_pkg::wave_q14(idx_ff + 1'b1);
      t_diff = (tsg_pkg::TAB_W+1)'(t1) - (tsg_pkg::TAB_W+1)'(t0);
      base_v = tsg_pkg::V_W'(t0) <<< F;
      step_v = t_diff * $signed({1'b0, frac_ff});
      abs_v  = v_ff[tsg_pkg::V_W-1] ? -v_ff : v_ff;
   end

   // ---------------------------------------------------------------------------
   // Sequencer and datapath next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      start_in      = start_ff;
      amp_in        = amp_ff;
      tc_in         = tc_ff;
      wave_in       = wave_ff;
      dir_in        = dir_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      dt_in         = dt_ff;
      sig_in        = sig_ff;
      neg_in        = neg_ff;
      idx_in        = idx_ff;
      frac_in       = frac_ff;
      v_in          = v_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_signal_in = rsp_signal_ff;
      rsp_active_in = rsp_active_ff;
      mul_start     = 1'b0;
      mul_mcand     = '0;
      div_start     = 1'b0;
      div_dividend  = '0;

      // configuration writes land directly; the user must issue them only while idle, the block does not enforce it
      if (csr_we) begin
         case (tsg_pkg::csr_index_type'(csr_index))
            tsg_pkg::CSR_AMPLITUDE:    amp_in  = csr_wdata[tsg_pkg::AMP_W-1:0];
            tsg_pkg::CSR_TIME_CONST:   tc_in   = csr_wdata[tsg_pkg::TC_W-1:0];
            tsg_pkg::CSR_WAVE_TYPE:    wave_in = csr_wdata[tsg_pkg::WAVE_W-1:0];
            tsg_pkg::CSR_DIRECTION_UP: dir_in  = csr_wdata[0];
            default: ;
         endcase
      end

      // response register drains independently of the sequencer
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.op;
               now_in   = req_chan.now_ms;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            sig_in = '0;
            if (op_ff == tsg_pkg::OP_START) begin
               // start re-arms, dropping any running waveform
               phase_in = PH_ARMED;
               state_in = S_OUT;
            end else if (phase_ff == PH_ARMED) begin
               // first tick after a start latches the time origin
               start_in = now_ff;
               phase_in = PH_RUN;
               state_in = S_OUT;
            end else if (phase_ff == PH_RUN) begin
               dt_in    = now_ff - start_ff;   // wraps at 32 bits
               state_in = S_EVAL;
            end else begin
               phase_in = PH_IDLE;
               state_in = S_OUT;
            end
         end

         S_EVAL: begin
            state_in = S_OUT;
            if (wave_ff == tsg_pkg::WAVE_TRIANGLE) begin
               if (dt_ff < tsg_pkg::TIME_W'(TRI_WAIT_MS)) begin
                  sig_in = '0;
               end else if (dt_ff < tsg_pkg::TIME_W'(tri_rise_end)) begin
                  mul_mcand = tsg_pkg::MUL_M_W'(tri_d[tsg_pkg::TC_W-1:0]);
                  mul_start = 1'b1;
                  state_in  = S_MUL;
               end else if (dt_ff < tsg_pkg::TIME_W'(tri_fall_end)) begin
                  mul_mcand = tsg_pkg::MUL_M_W'(tri_fall[tsg_pkg::TC_W-1:0]);
                  mul_start = 1'b1;
                  state_in  = S_MUL;
               end else begin
                  sig_in   = '0;
                  phase_in = PH_IDLE;
               end
            end else if (wave_ff == tsg_pkg::WAVE_WAVELET) begin
               // position reaches 120 exactly when dt reaches 15 tc
               if (dt_ff >= tsg_pkg::TIME_W'(tc15)) begin
                  sig_in   = '0;
                  phase_in = PH_IDLE;
               end else begin
                  div_dividend = {dt_ff[tsg_pkg::WAV_DT_W-1:0],
                                  {tsg_pkg::WAV_SHIFT{1'b0}}};
                  div_start    = 1'b1;
                  state_in     = S_DIV;
               end
            end else begin
               // doublet: wait, +A, -A, hold at zero until 13 tc
               if (dt_ff < tsg_pkg::TIME_W'(tc_eff)) begin
                  sig_in = '0;
               end else if (dt_ff < tsg_pkg::TIME_W'(tc2)) begin
                  sig_in = apply_sign(tsg_pkg::MAG_W'(amp_ff), !dir_ff);
               end else if (dt_ff < tsg_pkg::TIME_W'(tc3)) begin
                  sig_in = apply_sign(tsg_pkg::MAG_W'(amp_ff), dir_ff);
               end else if (dt_ff < tsg_pkg::TIME_W'(tc13)) begin
                  sig_in = '0;
               end else begin
                  sig_in   = '0;
                  phase_in = PH_IDLE;
               end
            end
         end

         S_MUL: begin
            if (mul_done) begin
               if (wave_ff == tsg_pkg::WAVE_TRIANGLE) begin
                  // A * ramp fits 25 bits; divide by tc next
                  div_dividend = tsg_pkg::DIV_N_W'(mul_product[tsg_pkg::TRI_PROD_W-1:0]);
                  div_start    = 1'b1;
                  state_in     = S_DIV;
               end else begin
                  // wavelet: drop the Q(14+F) fraction, truncating toward zero
                  sig_in = apply_sign(
                     mul_product[tsg_pkg::MUL_P_W-1:tsg_pkg::SCALE_SHIFT], neg_ff ^ !dir_ff);
                  state_in = S_OUT;
               end
            end
         end

         S_DIV: begin
            if (div_done) begin
               if (wave_ff == tsg_pkg::WAVE_TRIANGLE) begin
                  sig_in   = apply_sign(div_quotient[tsg_pkg::MAG_W-1:0], !dir_ff);
                  state_in = S_OUT;
               end else begin
                  state_in = S_MIRROR;
               end
            end
         end

         S_MIRROR: begin
            if (idx_fold >= tsg_pkg::WAV_IDX_W'(tsg_pkg::TAB_LAST)) begin
               idx_in  = tsg_pkg::TAB_IDX_W'(tsg_pkg::TAB_LAST);
               frac_in = '0;
            end else begin
               idx_in  = idx_fold[tsg_pkg::TAB_IDX_W-1:0];
               frac_in = pos_m[F-1:0];
            end
            state_in = S_INTERP;
         end

         S_INTERP: begin
            v_in     = base_v + step_v;
            state_in = S_WSTART;
         end

         S_WSTART: begin
            neg_in    = v_ff[tsg_pkg::V_W-1];
            mul_mcand = abs_v[tsg_pkg::MUL_M_W-1:0];
            mul_start = 1'b1;
            state_in  = S_MUL;
         end

         S_OUT: begin
            // load when the response register is empty or emptying this cycle
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_signal_in = sig_ff;
               rsp_active_in = (phase_ff != PH_IDLE);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         start_ff     <= '0;
         amp_ff       <= tsg_pkg::AMP_W'(200);
         tc_ff        <= tsg_pkg::TC_W'(500);
         wave_ff      <= '0;
         dir_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         amp_ff       <= amp_in;
         tc_ff        <= tc_in;
         wave_ff      <= wave_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      dt_ff         <= dt_in;
      sig_ff        <= sig_in;
      neg_ff        <= neg_in;
      idx_ff        <= idx_in;
      frac_ff       <= frac_in;
      v_ff          <= v_in;
      rsp_signal_ff <= rsp_signal_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.signal = rsp_signal_ff;
   assign rsp_chan.active = rsp_active_ff;

endmodule

// ===== rtl/core/tsg_checker.sv =====
// Port-level checks for the test signal generator, bound to the top level.
// Depends on tsg_pkg and test_signal_generator_macros.svh.
`timescale 1ns / 1ps
`include "test_signal_generator_macros.svh"

module tsg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [tsg_pkg::SIG_W-1:0]  rsp_signal,
   input logic                              rsp_active
);

   `TSG_ASSERT_NORST(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

   `TSG_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "request taken while busy")

   `TSG_ASSERT(a_inactive_is_zero, rsp_valid && !rsp_active |-> rsp_signal == '0, "nonzero idle sample")

   `TSG_ASSERT(a_signal_range, rsp_valid |-> (rsp_signal >= -tsg_pkg::SIG_LIMIT && rsp_signal <= tsg_pkg::SIG_LIMIT), "sample out of range")

   `TSG_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_signal), "stalled response changed")

endmodule

bind test_signal_generator tsg_checker u_tsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_signal (rsp_chan.signal),
   .rsp_active (rsp_chan.active)
);

// ===== verif/test_signal_generator_tb.sv =====
// Self-checking testbench for the test signal generator (doublet, triangle, wavelet).
// Depends on tsg_pkg, tsg_req_if, tsg_rsp_if and test_signal_generator from the RTL.
`timescale 1ns / 1ps

module test_signal_generator_tb;
   import tsg_pkg::*;

   // ------------------------------------------------------------------
   // Run shape
   // ------------------------------------------------------------------
   localparam int CLK_HALF         = 5;
   localparam int RESET_CYCLES     = 9;
   localparam int ITEM_TARGET      = 1900;
   localparam int QUIET_FROM       = 1700;       // no idling on either side past this
   localparam int LONG_HOLD_AT     = 400;        // response count that triggers the hold-off
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES     = 40;         // a bit above the slowest tick latency
   localparam int RUN_LIMIT_NS     = 4_000_000;  // several times the slowest run

   // ------------------------------------------------------------------
   // Codes and constants of the waveform
   // ------------------------------------------------------------------
   localparam logic              OP_TICK          = 1'b0;
   localparam logic [WAVE_W-1:0] WAVE_DOUBLET     = 2'd0;
   localparam logic [WAVE_W-1:0] WAVE_DOUBLET_ALT = 2'd3;
   localparam logic              DIR_UP           = 1'b1;
   localparam logic              DIR_DOWN         = 1'b0;
   localparam int AMP_RESET     = 200;
   localparam int TC_RESET      = 500;
   localparam int AMP_MAX       = 511;
   localparam int AMP_RATED     = 500;
   localparam int TC_MAX        = 65535;
   localparam int TRI_DELAY_MS  = 1000;          // triangle waits this long before ramping
   localparam int DOUBLET_END   = 13;            // doublet lasts 13 time constants
   localparam int WAVELET_END   = 15;            // 120 table steps at 8 per time constant
   localparam int POS_FRAC      = POS_FRAC_BITS;
   localparam int MIRROR_POINT  = TAB_LAST;      // table is walked forward then mirrored
   localparam int WAVELET_STEPS = 2 * TAB_LAST;

   typedef enum logic [1:0] {
      GEN_IDLE,
      GEN_ARMED,
      GEN_RUNNING
   } gen_phase_t;

   typedef struct packed {
      logic [SIG_W-1:0] signal;
      logic             active;
   } sample_t;

   // ------------------------------------------------------------------
   // Scoreboard: shadow registers, waveform predictor, expected samples
   // ------------------------------------------------------------------
   class excitation_scoreboard;
      logic [AMP_W-1:0]  amplitude;
      logic [TC_W-1:0]   time_const;
      logic [WAVE_W-1:0] wave_type;
      logic              direction_up;
      gen_phase_t        phase;
      logic [TIME_W-1:0] start_time;
      sample_t           expected_q[$];
      int                fails;
      int                checked;
      int                wave_tab[61];

      function new();
         amplitude    = AMP_RESET;
         time_const   = TC_RESET;
         wave_type    = WAVE_DOUBLET;
         direction_up = DIR_UP;
         phase        = GEN_IDLE;
         start_time   = '0;
         fails        = 0;
         checked      = 0;
         wave_tab = '{
            10, -8, -28, -48, -64, -75, -79, -72, -51, -13,
            38, 92, 141, 175, 190, 182, 146, 77, -21, -139,
            -259, -357, -413, -416, -356, -228, -38, 202, 444, 636,
            727, 709, 618, 498, 356, 128, -285, -908, -1602, -2071,
            -1987, -1235, -54, 1031, 1517, 1294, 819, 863, 1948, 3770,
            5100, 4350, 608, -5462, -11503, -14405, -11914, -4062, 6477, 15430,
            18930};
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_AMPLITUDE:    amplitude    = value[AMP_W-1:0];
            CSR_TIME_CONST:   time_const   = value[TC_W-1:0];
            CSR_WAVE_TYPE:    wave_type    = value[WAVE_W-1:0];
            CSR_DIRECTION_UP: direction_up = value[0];
            default: ;
         endcase
      endfunction

      function int triangle_value(longint unsigned dt, longint unsigned tc,
                                  longint unsigned a, output bit finished);
         finished = 1'b0;
         if (dt < TRI_DELAY_MS)
            return 0;
         if (dt < tc + TRI_DELAY_MS)
            return int'((a * (dt - TRI_DELAY_MS)) / tc);
         if (dt < 2 * tc + TRI_DELAY_MS)
            return int'((a * (2 * tc - (dt - TRI_DELAY_MS))) / tc);
         finished = 1'b1;
         return 0;
      endfunction

      function int doublet_value(longint unsigned dt, longint unsigned tc,
                                 longint unsigned a, output bit finished);
         finished = 1'b0;
         if (dt < tc)
            return 0;
         if (dt < 2 * tc)
            return int'(a);
         if (dt < 3 * tc)
            return -int'(a);
         if (dt < DOUBLET_END * tc)
            return 0;
         finished = 1'b1;
         return 0;
      endfunction

      // position has POS_FRAC fraction bits; 8 table steps per time constant
      function int wavelet_value(longint unsigned dt, longint unsigned tc,
                                 longint unsigned a, output bit finished);
         longint unsigned one;
         longint unsigned pos;
         longint unsigned idx;
         longint unsigned frac;
         longint          v;
         longint          mag;
         one      = 64'd1 << POS_FRAC;
         finished = 1'b0;
         pos      = (dt << (3 + POS_FRAC)) / tc;
         idx      = pos >> POS_FRAC;
         if (idx >= WAVELET_STEPS) begin
            finished = 1'b1;
            return 0;
         end
         if (idx >= MIRROR_POINT) begin
            pos = WAVELET_STEPS * one - pos;
            idx = pos >> POS_FRAC;
         end
         frac = pos & (one - 1);
         // exactly on the mirror point: last entry, nothing to interpolate
         if (idx >= MIRROR_POINT)
            v = longint'(wave_tab[MIRROR_POINT]) * longint'(one);
         else
            v = longint'(wave_tab[idx]) * longint'(one)
              + longint'(wave_tab[idx + 1] - wave_tab[idx]) * longint'(frac);
         mag = (v < 0) ? -v : v;
         mag = longint'(($unsigned(mag) * a) >> (Q_FRAC + POS_FRAC));
         return (v < 0) ? -int'(mag) : int'(mag);
      endfunction

      // Advance the shadow state by one accepted request and queue its sample.
      function void note_request(logic op, logic [TIME_W-1:0] now);
         int                sig;
         bit                finished;
         logic [TIME_W-1:0] elapsed;
         longint unsigned   dt;
         longint unsigned   tc;
         longint unsigned   a;
         sample_t           s;
         sig      = 0;
         finished = 1'b0;
         if (op == OP_START) begin
            phase = GEN_ARMED;
         end else if (phase == GEN_ARMED) begin
            start_time = now;
            phase      = GEN_RUNNING;
         end else if (phase == GEN_RUNNING) begin
            elapsed = now - start_time;    // wraps at 32 bits
            dt      = elapsed;
            tc      = (time_const == 0) ? 1 : time_const;
            a       = amplitude;
            case (wave_type)
               WAVE_TRIANGLE: sig = triangle_value(dt, tc, a, finished);
               WAVE_WAVELET:  sig = wavelet_value(dt, tc, a, finished);
               default:       sig = doublet_value(dt, tc, a, finished);
            endcase
            if (finished) begin
               sig   = 0;
               phase = GEN_IDLE;
            end
            if (direction_up == DIR_DOWN)
               sig = -sig;
         end else begin
            phase = GEN_IDLE;
         end
         s.signal = sig[SIG_W-1:0];
         s.active = (phase != GEN_IDLE);
         expected_q.push_back(s);
      endfunction

      function void check_sample(logic [SIG_W-1:0] sig, logic act);
         sample_t want;
         if (expected_q.size() == 0) begin
            fails++;
            $display("%0t: response with nothing expected: signal %0d active %0b",
                     $time, $signed(sig), act);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (sig !== want.signal) begin
            fails++;
            $display("%0t: signal mismatch: expected %0d, actual %0d",
                     $time, $signed(want.signal), $signed(sig));
         end
         if (act !== want.active) begin
            fails++;
            $display("%0t: active mismatch: expected %0b, actual %0b",
                     $time, want.active, act);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tsg_req_if req_chan();
   tsg_rsp_if rsp_chan();

   test_signal_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   excitation_scoreboard sb;

   int items_sent;
   int settings_used;
   int req_gap_pct;      // sender side, owned by the stimulus process
   int rsp_stall_pct;    // receiver side, written with <= by the stimulus
   int stall_left;
   int hold_left;
   bit quiet_tail;
   bit long_hold_done;

   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------
   // Receiver: checks every accepted response, stalls in short random
   // bursts, and once holds off for a long stretch so the block backs up
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_sample(rsp_chan.signal, rsp_chan.active);
            if (sb.checked == LONG_HOLD_AT && !long_hold_done) begin
               hold_left      = LONG_HOLD_CYCLES;
               long_hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(99) < rsp_stall_pct) begin
            stall_left = $urandom_range(2, 0);    // burst length picked at random
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver tasks
   // ------------------------------------------------------------------

   // One request transaction; valid stays up afterwards unless a gap follows.
   task automatic send_item(input logic op, input logic [TIME_W-1:0] now);
      if (!quiet_tail && $urandom_range(99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.op     <= op;
      req_chan.now_ms <= now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(op, now);
      items_sent++;
      if (items_sent >= QUIET_FROM)
         quiet_tail <= 1'b1;
   endtask

   // Registers only change with no transaction in flight.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Leaves csr_we high; the caller lowers it after its last write.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] amp, input logic [CSR_DATA_W-1:0] tc,
                             input logic [CSR_DATA_W-1:0] wave, input logic [CSR_DATA_W-1:0] dir);
      write_reg(CSR_AMPLITUDE, amp);
      write_reg(CSR_TIME_CONST, tc);
      write_reg(CSR_WAVE_TYPE, wave);
      write_reg(CSR_DIRECTION_UP, dir);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Random value into one random register; may land mid-waveform.
   task automatic poke_register();
      csr_index_type idx;
      idx = csr_index_type'($urandom_range(3));
      case (idx)
         CSR_AMPLITUDE:  write_reg(idx, $urandom_range(AMP_MAX));
         CSR_TIME_CONST: write_reg(idx, $urandom_range(1) ? $urandom_range(TC_MAX)
                                                           : $urandom_range(300));
         CSR_WAVE_TYPE:  write_reg(idx, $urandom_range(3));
         default:        write_reg(idx, $urandom_range(1));
      endcase
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] amp;
      logic [CSR_DATA_W-1:0] tc;
      case ($urandom_range(5))
         0:       amp = 0;
         1:       amp = AMP_MAX;
         2:       amp = AMP_RATED;
         default: amp = $urandom_range(AMP_MAX);
      endcase
      // mostly short time constants so a waveform fits in a few dozen ticks
      case ($urandom_range(9))
         0:       tc = 0;
         1:       tc = 1;
         2:       tc = TC_MAX;
         3:       tc = $urandom_range(TC_MAX);
         default: tc = $urandom_range(300, 2);
      endcase
      set_config(amp, tc, $urandom_range(3), $urandom_range(1));
   endtask

   // Well-formed run: arm, latch, then ticks walking forward through the
   // waveform and a little past its end. Occasional re-arms, time jumps and
   // register writes while it is running.
   task automatic run_waveform();
      longint unsigned   tc;
      longint unsigned   span;
      longint unsigned   dt;
      longint unsigned   offset;
      logic [TIME_W-1:0] base;
      int unsigned       stride;
      int                n;
      tc = (sb.time_const == 0) ? 1 : sb.time_const;
      case (sb.wave_type)
         WAVE_TRIANGLE: span = 2 * tc + TRI_DELAY_MS;
         WAVE_WAVELET:  span = WAVELET_END * tc;
         default:       span = DOUBLET_END * tc;
      endcase
      offset = (sb.wave_type == WAVE_TRIANGLE) ? TRI_DELAY_MS : 0;
      n      = $urandom_range(24, 6);
      stride = int'(span * 5 / (4 * n)) + 1;
      base   = $urandom();
      dt     = 0;
      send_item(OP_START, $urandom());
      send_item(OP_TICK, base);
      repeat (n) begin
         dt += $urandom_range(stride);
         // now and then land right on or just before a segment boundary
         if ($urandom_range(3) == 0 && dt >= offset)
            dt = ((dt - offset) / tc + 1) * tc + offset - $urandom_range(1);
         case ($urandom_range(39))
            0: send_item(OP_START, $urandom());
            1: send_item(OP_TICK, $urandom());
            2: begin
               wait_drained();
               poke_register();
               send_item(OP_TICK, base + dt[TIME_W-1:0]);
            end
            default: send_item(OP_TICK, base + dt[TIME_W-1:0]);
         endcase
      end
   endtask

   task automatic run_noise();
      repeat ($urandom_range(12, 4))
         send_item($urandom_range(1) ? OP_START : OP_TICK, $urandom());
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.op       = OP_TICK;
      req_chan.now_ms   = '0;
      rsp_chan.ready    = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_AMPLITUDE;
      csr_wdata         = '0;
      items_sent        = 0;
      settings_used     = 0;
      req_gap_pct       = 0;
      rsp_stall_pct     = 0;
      stall_left        = 0;
      hold_left         = 0;
      quiet_tail        = 1'b0;
      long_hold_done    = 1'b0;
      sb                = new();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // tick with nothing armed
      send_item(OP_TICK, 32'hFFFF_FFFF);

      // doublet at max amplitude, zero time constant (runs as 1 ms),
      // start latched right before the time counter wraps
      wait_drained();
      set_config(AMP_MAX, 0, WAVE_DOUBLET, DIR_UP);
      send_item(OP_START, '0);
      send_item(OP_TICK, 32'hFFFF_FFFF);
      send_item(OP_TICK, 32'd0);          // +A
      send_item(OP_TICK, 32'd1);          // -A
      send_item(OP_TICK, 32'd11);         // hold at zero, still active
      send_item(OP_TICK, 32'd12);         // finished

      // wavelet, inverted; tc = 8 puts dt = 60 exactly on the mirror point
      wait_drained();
      set_config(AMP_RATED, 8, WAVE_WAVELET, DIR_DOWN);
      send_item(OP_START, '0);
      send_item(OP_TICK, 32'd1000);
      send_item(OP_TICK, 32'd1059);
      send_item(OP_TICK, 32'd1060);
      send_item(OP_TICK, 32'd1061);
      send_item(OP_TICK, 32'd1120);       // past the end of the table
      // re-arm while armed, then while running
      send_item(OP_START, '0);
      send_item(OP_START, '0);
      send_item(OP_TICK, 32'd5);
      send_item(OP_TICK, 32'd9);
      send_item(OP_START, '0);

      // triangle at max amplitude and max time constant, inverted
      wait_drained();
      set_config(AMP_MAX, TC_MAX, WAVE_TRIANGLE, DIR_DOWN);
      send_item(OP_TICK, 32'd0);          // latches after the re-arm above
      send_item(OP_TICK, 32'd999);
      send_item(OP_TICK, TC_MAX + TRI_DELAY_MS);
      send_item(OP_TICK, 2 * TC_MAX + TRI_DELAY_MS - 1);
      send_item(OP_TICK, 2 * TC_MAX + TRI_DELAY_MS);

      // ---- random part ----
      wait_drained();
      set_config(AMP_RESET, TC_RESET, WAVE_DOUBLET_ALT, DIR_UP);
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(3) == 0) begin
            wait_drained();
            random_config();
         end else if ($urandom_range(7) == 0) begin
            wait_drained();
            poke_register();
         end
         // idling density changes per run; zero gives clean stretches
         case ($urandom_range(2))
            0: begin rsp_stall_pct <= 0;  req_gap_pct = 0;  end
            1: begin rsp_stall_pct <= 15; req_gap_pct = 15; end
            default: begin
               rsp_stall_pct <= $urandom_range(40);
               req_gap_pct = $urandom_range(40);
            end
         endcase
         if ($urandom_range(9) < 8)
            run_waveform();
         else
            run_noise();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions over %0d register settings: doublet, triangle, wavelet,",
               items_sent, settings_used);
      $display("both directions, re-arming, idle ticks, time wrap and a %0d-cycle output stall.",
               LONG_HOLD_CYCLES);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("test_signal_generator test passed");
      end else begin
         $display("test_signal_generator test failed");
      end
      $finish;
   end

   // hard stop if the handshakes ever lock up
   initial begin
      #RUN_LIMIT_NS;
      $display("test_signal_generator test failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tsg_pkg.sv
rtl/core/tsg_req_if.sv
rtl/core/tsg_rsp_if.sv
rtl/core/tsg_mul.sv
rtl/core/tsg_div.sv
rtl/core/test_signal_generator.sv
rtl/core/tsg_checker.sv
verif/test_signal_generator_tb.sv
